@@ design/atce_pkg.sv @@
package atce_pkg;

  localparam int MAX_ROW_COUNT    = 80;
  localparam int MAX_COL_COUNT    = 160;
  localparam int SEQ_BUFFER_BYTES = 64;

  localparam int ROW_W       = 7;
  localparam int COL_W       = 8;
  localparam int CODE_W      = 16;
  localparam int STORE_DEPTH = MAX_ROW_COUNT * MAX_COL_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(SEQ_BUFFER_BYTES);
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam int MIN_COLS   = 20;
  localparam int MIN_ROWS   = 8;
  localparam int RESET_COLS = 100;
  localparam int RESET_ROWS = 32;

  // register indexes (paddr[2])
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // character codes
  localparam logic [15:0] CH_BEL    = 16'h0007;
  localparam logic [15:0] CH_BS     = 16'h0008;
  localparam logic [15:0] CH_LF     = 16'h000a;
  localparam logic [15:0] CH_CR     = 16'h000d;
  localparam logic [15:0] CH_ESC    = 16'h001b;
  localparam logic [15:0] CH_SPACE  = 16'h0020;
  localparam logic [15:0] CH_LBRACK = 16'h005b;
  localparam logic [15:0] CH_RBRACK = 16'h005d;
  localparam logic [15:0] CH_BSLASH = 16'h005c;
  localparam logic [15:0] CH_LOW_C  = 16'h0063;
  localparam logic [15:0] FINAL_LO  = 16'h0040;
  localparam logic [15:0] FINAL_HI  = 16'h007e;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [7:0]  CH_SEMI   = 8'h3b;

  // CSI final bytes
  localparam logic [7:0] CSI_UP    = 8'h41;
  localparam logic [7:0] CSI_DOWN  = 8'h42;
  localparam logic [7:0] CSI_RIGHT = 8'h43;
  localparam logic [7:0] CSI_LEFT  = 8'h44;
  localparam logic [7:0] CSI_POS   = 8'h48;
  localparam logic [7:0] CSI_POS_F = 8'h66;
  localparam logic [7:0] CSI_ED    = 8'h4a;
  localparam logic [7:0] CSI_EL    = 8'h4b;
  localparam logic [7:0] CSI_SAVE  = 8'h73;
  localparam logic [7:0] CSI_REST  = 8'h75;

  typedef enum logic [2:0] {
    MODE_NORMAL, MODE_ESC, MODE_CSI, MODE_OSC, MODE_OSC_ESC
  } mode_t;

  typedef enum logic [2:0] {
    PH_FIRST_NONE, PH_FIRST_DIG, PH_SECOND_NONE, PH_SECOND_DIG, PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_FINISH, S_LF, S_PUT, S_SCR_RD, S_SCR_WR,
    S_BLANK, S_CLEAR, S_ERASE, S_RD, S_RD_CAP, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LATCH, CMD_DECODE, CMD_FINISH, CMD_LF, CMD_PUT, CMD_SCR_RD,
    CMD_SCR_WR, CMD_BLANK, CMD_CLEAR, CMD_ERASE, CMD_RD, CMD_RD_CAP, CMD_OUT
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_READ, OP_LF, OP_PUT, OP_CLEAR, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  dec_op;
    logic wrap_first;
    logic lf_scroll;
    logic put_wraps;
    logic fin_clear;
    logic fin_erase;
    logic x_last;
    logic scr_last;
    logic clr_last;
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] cell_code;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic               idx;
    logic [PDATA_W-1:0] data;
  } cfg_wr_t;

endpackage

@@ design/atce_ctrl.sv @@
module atce_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_stall,
  input  atce_pkg::status_t status,
  output atce_pkg::cmd_t   cmd,
  output logic             in_stall,
  output logic             out_valid
);

  atce_pkg::state_t state, state_next;
  logic pending_put, pending_put_next;
  logic out_valid_next;
  logic out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= atce_pkg::S_INIT;
      pending_put <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      pending_put <= pending_put_next;
      out_valid   <= out_valid_next;
    end
  end

  assign out_load = (state == atce_pkg::S_DONE) && (!out_valid || !out_stall);
  assign in_stall = (state != atce_pkg::S_IDLE);

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next       = state;
    pending_put_next = pending_put;
    unique case (state)
      atce_pkg::S_INIT: if (status.clr_last) state_next = atce_pkg::S_IDLE;
      atce_pkg::S_IDLE: if (in_valid) state_next = atce_pkg::S_DECODE;
      atce_pkg::S_DECODE: begin
        unique case (status.dec_op)
          atce_pkg::OP_READ:   state_next = atce_pkg::S_RD;
          atce_pkg::OP_LF:     state_next = atce_pkg::S_LF;
          atce_pkg::OP_PUT: begin
            pending_put_next = status.wrap_first;
            state_next = status.wrap_first ? atce_pkg::S_LF : atce_pkg::S_PUT;
          end
          atce_pkg::OP_CLEAR:  state_next = atce_pkg::S_CLEAR;
          atce_pkg::OP_FINISH: state_next = atce_pkg::S_FINISH;
          default:             state_next = atce_pkg::S_DONE;
        endcase
      end
      atce_pkg::S_FINISH: begin
        priority if (status.fin_clear) state_next = atce_pkg::S_CLEAR;
        else if (status.fin_erase) state_next = atce_pkg::S_ERASE;
        else state_next = atce_pkg::S_DONE;
      end
      atce_pkg::S_LF: begin
        priority if (status.lf_scroll) state_next = atce_pkg::S_SCR_RD;
        else if (pending_put) state_next = atce_pkg::S_PUT;
        else state_next = atce_pkg::S_DONE;
      end
      atce_pkg::S_PUT: begin
        pending_put_next = 1'b0;
        state_next = status.put_wraps ? atce_pkg::S_LF : atce_pkg::S_DONE;
      end
      atce_pkg::S_SCR_RD: state_next = atce_pkg::S_SCR_WR;
      atce_pkg::S_SCR_WR:
        state_next = status.scr_last ? atce_pkg::S_BLANK : atce_pkg::S_SCR_RD;
      atce_pkg::S_BLANK:
        if (status.x_last) state_next = pending_put ? atce_pkg::S_PUT : atce_pkg::S_DONE;
      atce_pkg::S_CLEAR: if (status.clr_last) state_next = atce_pkg::S_DONE;
      atce_pkg::S_ERASE: if (status.x_last) state_next = atce_pkg::S_DONE;
      atce_pkg::S_RD:     state_next = atce_pkg::S_RD_CAP;
      atce_pkg::S_RD_CAP: state_next = atce_pkg::S_DONE;
      atce_pkg::S_DONE:   if (out_load) state_next = atce_pkg::S_IDLE;
      default:            state_next = atce_pkg::S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd = atce_pkg::CMD_NONE;
    unique case (state)
      atce_pkg::S_INIT:   cmd = atce_pkg::CMD_CLEAR;
      atce_pkg::S_IDLE:   if (in_valid) cmd = atce_pkg::CMD_LATCH;
      atce_pkg::S_DECODE: cmd = atce_pkg::CMD_DECODE;
      atce_pkg::S_FINISH: cmd = atce_pkg::CMD_FINISH;
      atce_pkg::S_LF:     cmd = atce_pkg::CMD_LF;
      atce_pkg::S_PUT:    cmd = atce_pkg::CMD_PUT;
      atce_pkg::S_SCR_RD: cmd = atce_pkg::CMD_SCR_RD;
      atce_pkg::S_SCR_WR: cmd = atce_pkg::CMD_SCR_WR;
      atce_pkg::S_BLANK:  cmd = atce_pkg::CMD_BLANK;
      atce_pkg::S_CLEAR:  cmd = atce_pkg::CMD_CLEAR;
      atce_pkg::S_ERASE:  cmd = atce_pkg::CMD_ERASE;
      atce_pkg::S_RD:     cmd = atce_pkg::CMD_RD;
      atce_pkg::S_RD_CAP: cmd = atce_pkg::CMD_RD_CAP;
      atce_pkg::S_DONE:   if (out_load) cmd = atce_pkg::CMD_OUT;
      default:            cmd = atce_pkg::CMD_NONE;
    endcase
  end

endmodule

@@ design/atce_dp.sv @@
module atce_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  atce_pkg::cmd_t                cmd,
  input  atce_pkg::cfg_wr_t             cfg_wr,
  input  atce_pkg::in_item_t            in_data,
  output atce_pkg::status_t             status,
  output atce_pkg::out_item_t           out_data,
  output logic [atce_pkg::COL_W-1:0]    vis_cols,
  output logic [atce_pkg::ROW_W-1:0]    vis_rows
);

  localparam int AW = atce_pkg::ADDR_W;
  localparam int RW = atce_pkg::ROW_W;
  localparam int CW = atce_pkg::COL_W;

  function automatic logic [15:0] add_digit(input logic [15:0] n, input logic [3:0] d);
    logic [19:0] r;
    r = 20'(n) * 20'd10 + 20'(d);
    return (r > 20'd65535) ? 16'hffff : r[15:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(atce_pkg::MAX_COL_COUNT) + AW'(c);
  endfunction

  logic [atce_pkg::CODE_W-1:0] mem [atce_pkg::STORE_DEPTH];
  logic [atce_pkg::CODE_W-1:0] rdata;

  atce_pkg::in_item_t  item, item_next;
  atce_pkg::out_item_t out_q, out_q_next;
  logic [CW-1:0] cur_col, cur_col_next, saved_col, saved_col_next;
  logic [RW-1:0] cur_row, cur_row_next, saved_row, saved_row_next;
  logic [CW-1:0] vis_cols_next;
  logic [RW-1:0] vis_rows_next;
  atce_pkg::mode_t  mode, mode_next;
  atce_pkg::phase_t phase, phase_next;
  logic [atce_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [15:0] first_num, first_num_next, second_num, second_num_next;
  logic [7:0]  last_byte, last_byte_next;
  logic [CW-1:0] scan_x, scan_x_next;
  logic [RW-1:0] scan_y, scan_y_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [atce_pkg::CODE_W-1:0] rd_cell, rd_cell_next;

  logic [15:0] code;
  logic [7:0]  lb;
  logic        is_digit, store_ok, is_final, rd_in_range;
  logic [3:0]  digit_val;
  logic [15:0] a_val, b_val;
  logic [16:0] row_sum, col_sum;
  logic [7:0]  new_cols, wc;
  logic [6:0]  new_rows, wr_;
  logic        we, re;
  logic [AW-1:0] waddr, raddr;
  logic [atce_pkg::CODE_W-1:0] wdata;

  assign code      = item.code;
  assign lb        = code[7:0];
  assign is_digit  = (lb >= atce_pkg::CH_ZERO) && (lb <= atce_pkg::CH_NINE);
  assign digit_val = 4'(lb - atce_pkg::CH_ZERO);
  assign store_ok  = 32'(cnt) < 32'(atce_pkg::SEQ_BUFFER_BYTES - 1);
  assign is_final  = (code >= atce_pkg::FINAL_LO) && (code <= atce_pkg::FINAL_HI);
  assign rd_in_range = (32'(item.read_row) < 32'(atce_pkg::MAX_ROW_COUNT)) &&
                       (32'(item.read_col) < 32'(atce_pkg::MAX_COL_COUNT));
  assign a_val = (phase == atce_pkg::PH_FIRST_NONE) ? 16'd1 : first_num;
  assign b_val = (phase == atce_pkg::PH_SECOND_DIG || phase == atce_pkg::PH_DONE) ?
                 second_num : 16'd1;
  assign row_sum = 17'(cur_row) + 17'(a_val);
  assign col_sum = 17'(cur_col) + 17'(a_val);

  assign wc  = cfg_wr.data[7:0];
  assign wr_ = cfg_wr.data[6:0];
  assign new_cols = (32'(wc) < atce_pkg::MIN_COLS) ? 8'(atce_pkg::MIN_COLS) :
                    (32'(wc) > atce_pkg::MAX_COL_COUNT) ? 8'(atce_pkg::MAX_COL_COUNT) : wc;
  assign new_rows = (32'(wr_) < atce_pkg::MIN_ROWS) ? 7'(atce_pkg::MIN_ROWS) :
                    (32'(wr_) > atce_pkg::MAX_ROW_COUNT) ? 7'(atce_pkg::MAX_ROW_COUNT) : wr_;

  // status
  always_comb begin
    status = '0;
    status.dec_op = atce_pkg::OP_NONE;
    if (item.kind) begin
      status.dec_op = atce_pkg::OP_READ;
    end else begin
      unique case (mode)
        atce_pkg::MODE_NORMAL: begin
          priority if (code == atce_pkg::CH_ESC) status.dec_op = atce_pkg::OP_NONE;
          else if (code == atce_pkg::CH_LF) status.dec_op = atce_pkg::OP_LF;
          else if (code < atce_pkg::CH_SPACE) status.dec_op = atce_pkg::OP_NONE;
          else status.dec_op = atce_pkg::OP_PUT;
        end
        atce_pkg::MODE_ESC:
          if (code == atce_pkg::CH_LOW_C) status.dec_op = atce_pkg::OP_CLEAR;
        atce_pkg::MODE_CSI:
          if (is_final) status.dec_op = atce_pkg::OP_FINISH;
        default: status.dec_op = atce_pkg::OP_NONE;
      endcase
    end
    status.wrap_first = cur_col >= vis_cols;
    status.lf_scroll  = (8'(cur_row) + 8'd1) >= 8'(vis_rows);
    status.put_wraps  = (9'(cur_col) + 9'd1) >= 9'(vis_cols);
    status.fin_clear  = (last_byte == atce_pkg::CSI_ED) && (a_val == 16'd2 || a_val == 16'd3);
    status.fin_erase  = (last_byte == atce_pkg::CSI_EL) && (cur_col < vis_cols);
    status.x_last     = scan_x == (vis_cols - 8'd1);
    status.scr_last   = status.x_last && (scan_y == (vis_rows - 7'd1));
    status.clr_last   = clr_addr == AW'(atce_pkg::STORE_DEPTH - 1);
  end

  // register updates
  always_comb begin
    item_next       = item;
    out_q_next      = out_q;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    saved_col_next  = saved_col;
    saved_row_next  = saved_row;
    vis_cols_next   = vis_cols;
    vis_rows_next   = vis_rows;
    mode_next       = mode;
    phase_next      = phase;
    cnt_next        = cnt;
    first_num_next  = first_num;
    second_num_next = second_num;
    last_byte_next  = last_byte;
    scan_x_next     = scan_x;
    scan_y_next     = scan_y;
    clr_addr_next   = '0;
    rd_cell_next    = rd_cell;

    if (cfg_wr.en) begin
      if (cfg_wr.idx == atce_pkg::REG_COLS) begin
        vis_cols_next = new_cols;
        if (cur_col >= new_cols) cur_col_next = new_cols - 8'd1;
      end else begin
        vis_rows_next = new_rows;
        if (cur_row >= new_rows) cur_row_next = new_rows - 7'd1;
      end
    end

    unique case (cmd)
      atce_pkg::CMD_LATCH: begin
        item_next    = in_data;
        rd_cell_next = '0;
      end
      atce_pkg::CMD_DECODE: if (!item.kind) begin
        unique case (mode)
          atce_pkg::MODE_NORMAL: begin
            priority if (code == atce_pkg::CH_ESC) mode_next = atce_pkg::MODE_ESC;
            else if (code == atce_pkg::CH_CR) cur_col_next = '0;
            else if (code == atce_pkg::CH_BS) begin
              if (cur_col != '0) cur_col_next = cur_col - 8'd1;
            end else begin
            end
          end
          atce_pkg::MODE_ESC: begin
            priority if (code == atce_pkg::CH_LBRACK) begin
              mode_next       = atce_pkg::MODE_CSI;
              cnt_next        = '0;
              first_num_next  = '0;
              second_num_next = '0;
              phase_next      = atce_pkg::PH_FIRST_NONE;
            end else if (code == atce_pkg::CH_RBRACK) begin
              mode_next = atce_pkg::MODE_OSC;
            end else begin
              if (code == atce_pkg::CH_LOW_C) begin
                cur_col_next = '0;
                cur_row_next = '0;
              end
              mode_next = atce_pkg::MODE_NORMAL;
            end
          end
          atce_pkg::MODE_CSI: begin
            if (store_ok) begin
              cnt_next       = cnt + 1'b1;
              last_byte_next = lb;
              unique case (phase)
                atce_pkg::PH_FIRST_NONE, atce_pkg::PH_FIRST_DIG: begin
                  if (is_digit) begin
                    first_num_next = add_digit(first_num, digit_val);
                    phase_next     = atce_pkg::PH_FIRST_DIG;
                  end else begin
                    if (phase == atce_pkg::PH_FIRST_NONE) first_num_next = 16'd1;
                    if (lb == atce_pkg::CH_SEMI) begin
                      phase_next = atce_pkg::PH_SECOND_NONE;
                    end else begin
                      second_num_next = 16'd1;
                      phase_next      = atce_pkg::PH_DONE;
                    end
                  end
                end
                atce_pkg::PH_SECOND_NONE, atce_pkg::PH_SECOND_DIG: begin
                  if (is_digit) begin
                    second_num_next = add_digit(second_num, digit_val);
                    phase_next      = atce_pkg::PH_SECOND_DIG;
                  end else begin
                    if (phase == atce_pkg::PH_SECOND_NONE) second_num_next = 16'd1;
                    phase_next = atce_pkg::PH_DONE;
                  end
                end
                default: ;
              endcase
            end
            if (is_final) begin
              mode_next = atce_pkg::MODE_NORMAL;
              cnt_next  = '0;
            end
          end
          atce_pkg::MODE_OSC: begin
            priority if (code == atce_pkg::CH_BEL) mode_next = atce_pkg::MODE_NORMAL;
            else if (code == atce_pkg::CH_ESC) mode_next = atce_pkg::MODE_OSC_ESC;
            else mode_next = atce_pkg::MODE_OSC;
          end
          default: begin
            priority if (code == atce_pkg::CH_BSLASH) mode_next = atce_pkg::MODE_NORMAL;
            else if (code != atce_pkg::CH_ESC) mode_next = atce_pkg::MODE_OSC;
            else mode_next = mode;
          end
        endcase
      end
      atce_pkg::CMD_FINISH: begin
        scan_x_next = cur_col;
        unique case (last_byte)
          atce_pkg::CSI_UP:
            cur_row_next = (a_val >= 16'(cur_row)) ? '0 : RW'(16'(cur_row) - a_val);
          atce_pkg::CSI_DOWN:
            cur_row_next = (row_sum >= 17'(vis_rows)) ? vis_rows - 7'd1 : RW'(row_sum);
          atce_pkg::CSI_RIGHT:
            cur_col_next = (col_sum >= 17'(vis_cols)) ? vis_cols - 8'd1 : CW'(col_sum);
          atce_pkg::CSI_LEFT:
            cur_col_next = (a_val >= 16'(cur_col)) ? '0 : CW'(16'(cur_col) - a_val);
          atce_pkg::CSI_POS, atce_pkg::CSI_POS_F: begin
            cur_row_next = (a_val == 16'd0) ? '0 :
                           (a_val >= 16'(vis_rows)) ? vis_rows - 7'd1 : RW'(a_val - 16'd1);
            cur_col_next = (b_val == 16'd0) ? '0 :
                           (b_val >= 16'(vis_cols)) ? vis_cols - 8'd1 : CW'(b_val - 16'd1);
          end
          atce_pkg::CSI_ED: if (status.fin_clear) begin
            cur_col_next = '0;
            cur_row_next = '0;
          end
          atce_pkg::CSI_SAVE: begin
            saved_col_next = cur_col;
            saved_row_next = cur_row;
          end
          atce_pkg::CSI_REST: begin
            cur_col_next = saved_col;
            cur_row_next = saved_row;
          end
          default: ;
        endcase
      end
      atce_pkg::CMD_LF: begin
        cur_col_next = '0;
        if (status.lf_scroll) begin
          cur_row_next = vis_rows - 7'd1;
          scan_x_next  = '0;
          scan_y_next  = 7'd1;
        end else begin
          cur_row_next = cur_row + 7'd1;
        end
      end
      atce_pkg::CMD_PUT: cur_col_next = cur_col + 8'd1;
      atce_pkg::CMD_SCR_WR: begin
        if (status.x_last) begin
          scan_x_next = '0;
          scan_y_next = scan_y + 7'd1;
        end else begin
          scan_x_next = scan_x + 8'd1;
        end
      end
      atce_pkg::CMD_BLANK, atce_pkg::CMD_ERASE: scan_x_next = scan_x + 8'd1;
      atce_pkg::CMD_CLEAR:  clr_addr_next = clr_addr + 1'b1;
      atce_pkg::CMD_RD_CAP: rd_cell_next = rd_in_range ? rdata : '0;
      atce_pkg::CMD_OUT: begin
        out_q_next.cell_code  = rd_cell;
        out_q_next.cursor_col = cur_col;
        out_q_next.cursor_row = cur_row;
      end
      default: ;
    endcase
  end

  // store port selection
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = atce_pkg::CH_SPACE;
    unique case (cmd)
      atce_pkg::CMD_PUT: begin
        we    = 1'b1;
        waddr = cell_addr(cur_row, cur_col);
        wdata = code;
      end
      atce_pkg::CMD_SCR_RD: begin
        re    = 1'b1;
        raddr = cell_addr(scan_y, scan_x);
      end
      atce_pkg::CMD_SCR_WR: begin
        we    = 1'b1;
        waddr = cell_addr(scan_y - 7'd1, scan_x);
        wdata = rdata;
      end
      atce_pkg::CMD_BLANK: begin
        we    = 1'b1;
        waddr = cell_addr(vis_rows - 7'd1, scan_x);
      end
      atce_pkg::CMD_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      atce_pkg::CMD_ERASE: begin
        we    = 1'b1;
        waddr = cell_addr(cur_row, scan_x);
      end
      atce_pkg::CMD_RD: begin
        re    = 1'b1;
        raddr = cell_addr(item.read_row, item.read_col);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col    <= '0;
      cur_row    <= '0;
      saved_col  <= '0;
      saved_row  <= '0;
      vis_cols   <= CW'(atce_pkg::RESET_COLS);
      vis_rows   <= RW'(atce_pkg::RESET_ROWS);
      mode       <= atce_pkg::MODE_NORMAL;
      phase      <= atce_pkg::PH_FIRST_NONE;
      cnt        <= '0;
      first_num  <= '0;
      second_num <= '0;
      last_byte  <= '0;
      clr_addr   <= '0;
    end else begin
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      saved_col  <= saved_col_next;
      saved_row  <= saved_row_next;
      vis_cols   <= vis_cols_next;
      vis_rows   <= vis_rows_next;
      mode       <= mode_next;
      phase      <= phase_next;
      cnt        <= cnt_next;
      first_num  <= first_num_next;
      second_num <= second_num_next;
      last_byte  <= last_byte_next;
      clr_addr   <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    item    <= item_next;
    out_q   <= out_q_next;
    scan_x  <= scan_x_next;
    scan_y  <= scan_y_next;
    rd_cell <= rd_cell_next;
  end

  assign out_data = out_q;

endmodule

@@ design/ansi_terminal_character_engine.sv @@
// Channel   Direction  Handshake          Payload
// in        request    in_valid/in_stall  in_data  (kind, code, read_row, read_col)
// out       result     out_valid/out_stall out_data (cell_code, cursor_col, cursor_row)
// cfg       APB write  psel/penable/pwrite paddr, pwdata, prdata (pready tied high)
//
// One request is worked on at a time: a control or sequence byte, a printable code,
// a line feed, a CSI final byte or a cell read; a printable code that wraps adds a line feed.
// A scrolling line feed copies each visible row up one and blanks the bottom row; ESC c and
// CSI 2J/3J sweep all 12800 cells, one per cycle; CSI K erases one column per cycle.
// Reset: a clearing pass writes spaces to all 12800 cells, in_stall high, config taken.
// Next request is taken in the cycle after the load, even while the result still waits.
module ansi_terminal_character_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  atce_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output atce_pkg::out_item_t                out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [atce_pkg::PADDR_W-1:0]       paddr,
  input  logic [atce_pkg::PDATA_W-1:0]       pwdata,
  output logic [atce_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  atce_pkg::cmd_t    cmd;
  atce_pkg::status_t status;
  atce_pkg::cfg_wr_t cfg_wr;
  logic [atce_pkg::COL_W-1:0] vis_cols;
  logic [atce_pkg::ROW_W-1:0] vis_rows;

  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[2];
  assign cfg_wr.data = pwdata;

  // register readback
  assign prdata = (paddr[2] == atce_pkg::REG_COLS) ?
                  atce_pkg::PDATA_W'(vis_cols) : atce_pkg::PDATA_W'(vis_rows);

  atce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  atce_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_wr   (cfg_wr),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data),
    .vis_cols (vis_cols),
    .vis_rows (vis_rows)
  );

  // an accepted request keeps the input stalled while it is worked on
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // loading the result register always presents a result next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (cmd == atce_pkg::CMD_OUT) |=> out_valid)
    else $error("result load lost");

  // reported cursor stays inside the store
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.cursor_row) < atce_pkg::MAX_ROW_COUNT) &&
                  (32'(out_data.cursor_col) < atce_pkg::MAX_COL_COUNT))
    else $error("cursor outside store");

endmodule
